// ===== rtl/core/record_key_exchange_sorter_top_macros.svh =====
`ifndef RECORD_KEY_EXCHANGE_SORTER_TOP_MACROS_SVH
`define RECORD_KEY_EXCHANGE_SORTER_TOP_MACROS_SVH

// Concurrent check on the rising clock edge, idle while reset is asserted.
`define RKES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds while reset is asserted.
`define RKES_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rkes_pkg.sv =====
package rkes_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    localparam int KEY_W  = 7;
    localparam int TAG_W  = 8;
    localparam int DATA_W = ((KEY_W + TAG_W + 7) / 8) * 8;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } rec_t;

endpackage

// ===== rtl/core/record_key_exchange_sorter_top.sv =====
// Record sorter. Records (a 7-bit key and an 8-bit tag) arrive one per
// transaction on the slave side and are written into a 16-entry record
// memory. A record with tlast set, or the record that fills the memory,
// closes the set. The block then sorts the set in place with an exchange
// sort (for every i and every j, swap when key[i] < key[j]), which leaves
// the keys in ascending order, and sends the records out on the master side
// in that order with tlast on the final one. Records load at one per cycle
// while the slave side offers them. The sort holds record i in a register
// and streams the memory past it through the single read port; emitting
// reads each record from the memory and then moves it into the output
// register, as the read data of the memory is registered. No input is taken
// while a set is being sorted or emitted; the next set may start loading as
// soon as the last result sits in the output register.
`include "record_key_exchange_sorter_top_macros.svh"

module record_key_exchange_sorter_top
    import rkes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [6:0] key_years, [14:7] record_tag, [15] zero
    input  logic              s_axis_tlast,   // last_item
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [6:0] out_key, [14:7] out_tag, [15] zero
    output logic              m_axis_tlast    // out_last
);

    // Sequencer states.
    localparam logic [2:0] ST_LOAD = 3'd0;  // collect records
    localparam logic [2:0] ST_RDA  = 3'd1;  // read record i
    localparam logic [2:0] ST_LDA  = 3'd2;  // capture record i, start inner sweep
    localparam logic [2:0] ST_CMP  = 3'd3;  // compare and exchange with record j
    localparam logic [2:0] ST_WBA  = 3'd4;  // write record i back
    localparam logic [2:0] ST_ERD  = 3'd5;  // read record k for output
    localparam logic [2:0] ST_EOUT = 3'd6;  // move record k into the output register

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] a_reg, a_next;
    logic [IDX_W-1:0] b_reg, b_next;
    logic [IDX_W-1:0] k_reg, k_next;
    rec_t             cur_reg, cur_next;

    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;
    rec_t             out_rec_reg, out_rec_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    rec_t             ram_wdata;
    rec_t             ram_rdata;

    logic             in_fire;
    logic             out_fire;
    rec_t             in_rec;
    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] a_inc;
    logic [CNT_W-1:0] b_inc;
    logic [CNT_W-1:0] k_inc;

    rkes_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (MAX_ITEMS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;

    assign in_rec.key = s_axis_tdata[KEY_W-1:0];
    assign in_rec.tag = s_axis_tdata[KEY_W+TAG_W-1:KEY_W];

    assign fill_inc = fill_reg + CNT_W'(1);
    assign a_inc    = {1'b0, a_reg} + CNT_W'(1);
    assign b_inc    = {1'b0, b_reg} + CNT_W'(1);
    assign k_inc    = {1'b0, k_reg} + CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        ram_we         = 1'b0;
        ram_waddr      = fill_reg[IDX_W-1:0];
        ram_wdata      = in_rec;
        ram_raddr      = a_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_inc;
                    if (s_axis_tlast || (fill_inc == CNT_W'(MAX_ITEMS)))
                    begin
                        a_next     = '0;
                        state_next = ST_RDA;
                    end
                end
            end
            ST_RDA:
            begin
                ram_raddr  = a_reg;
                state_next = ST_LDA;
            end
            ST_LDA:
            begin
                cur_next   = ram_rdata;
                ram_raddr  = '0;
                b_next     = '0;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                // Record j never meets record i itself: equal keys never swap,
                // and the memory copy of record i is stale while it is held.
                if ((b_reg != a_reg) && (cur_reg.key < ram_rdata.key))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = b_reg;
                    ram_wdata = cur_reg;
                    cur_next  = ram_rdata;
                end
                if (b_inc == fill_reg)
                begin
                    state_next = ST_WBA;
                end
                else
                begin
                    b_next    = b_inc[IDX_W-1:0];
                    ram_raddr = b_inc[IDX_W-1:0];
                end
            end
            ST_WBA:
            begin
                ram_we    = 1'b1;
                ram_waddr = a_reg;
                ram_wdata = cur_reg;
                if (a_inc == fill_reg)
                begin
                    k_next     = '0;
                    state_next = ST_ERD;
                end
                else
                begin
                    a_next     = a_inc[IDX_W-1:0];
                    ram_raddr  = a_inc[IDX_W-1:0];
                    state_next = ST_LDA;
                end
            end
            ST_ERD:
            begin
                ram_raddr = k_reg;
                if (!out_valid_reg || out_fire)
                begin
                    state_next = ST_EOUT;
                end
            end
            ST_EOUT:
            begin
                out_rec_next   = ram_rdata;
                out_valid_next = 1'b1;
                out_last_next  = (k_inc == fill_reg);
                if (k_inc == fill_reg)
                begin
                    fill_next  = '0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    k_next     = k_inc[IDX_W-1:0];
                    state_next = ST_ERD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            fill_reg      <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = DATA_W'(out_rec_reg);
    assign m_axis_tlast  = out_last_reg;

    // The output register is only refilled once its previous result has left.
    `RKES_ASSERT(a_out_no_overwrite, (state_reg == ST_EOUT) |-> !out_valid_reg, "output register overwritten while holding a result")

    // A record is never written past the end of the memory.
    `RKES_ASSERT(a_fill_in_range, in_fire |-> (fill_reg < CNT_W'(MAX_ITEMS)), "record accepted with a full memory")

    // After record i is written back, the sweep either moves on or emits.
    `RKES_ASSERT(a_wba_next, (state_reg == ST_WBA) |=> ((state_reg == ST_LDA) || (state_reg == ST_ERD)), "bad state after write-back")

endmodule

// ===== rtl/core/rkes_ram.sv =====
// Simple dual-port memory: one write port, one read port, registered read data.
module rkes_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== bench/tb.sv =====
module tb;
    import rkes_pkg::*;

    localparam int PAD_W       = DATA_W - KEY_W - TAG_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 280;
    localparam int SETTLE_CYCLES = 40;

    // One record as it leaves the sorter: key, tag and the end-of-set mark.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } sorted_rec_t;

    // Ways the output side holds off the master stream.
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_TOGGLE
    } stall_mode_t;

    // Key distributions for the random sets. Narrow and extreme ranges force
    // many equal keys, which exercises the ordering that the exchange loop
    // leaves among ties.
    typedef enum logic [1:0] {
        KEYS_FULL,
        KEYS_NARROW,
        KEYS_EXTREME,
        KEYS_HIGH
    } key_mode_t;

    // The scoreboard keeps its own copy of the record memory and fill count.
    // Every accepted input transaction goes through note_record(); once a set
    // closes, it is sorted with the same exchange loop as the hardware and
    // the records are queued in the order they must appear on the master side.
    class sorted_record_board;
        logic [KEY_W-1:0] key_mem [MAX_ITEMS];
        logic [TAG_W-1:0] tag_mem [MAX_ITEMS];
        int               fill;
        sorted_rec_t      due_q [$];
        int               errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Sort the current set in place (swap i and j whenever key[i] < key[j],
        // for every i and every j) and queue it with the mark on the final record.
        function void release_sorted_set();
            logic [KEY_W-1:0] held_key;
            logic [TAG_W-1:0] held_tag;
            sorted_rec_t      rec;
            for (int i = 0; i < fill; i++) begin
                for (int j = 0; j < fill; j++) begin
                    if (key_mem[i] < key_mem[j]) begin
                        held_key   = key_mem[i];
                        held_tag   = tag_mem[i];
                        key_mem[i] = key_mem[j];
                        tag_mem[i] = tag_mem[j];
                        key_mem[j] = held_key;
                        tag_mem[j] = held_tag;
                    end
                end
            end
            for (int i = 0; i < fill; i++) begin
                rec.key  = key_mem[i];
                rec.tag  = tag_mem[i];
                rec.last = (i == fill - 1);
                due_q.push_back(rec);
            end
            fill = 0;
        endfunction

        // A record marked last closes the set, and so does the record that
        // fills the memory even when it carries no mark.
        function void note_record(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic mark);
            if (fill >= MAX_ITEMS)
                fill = 0;
            key_mem[fill] = k;
            tag_mem[fill] = t;
            fill++;
            if (mark || fill == MAX_ITEMS)
                release_sorted_set();
        endfunction

        function void check_output(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t, logic mark);
            sorted_rec_t want;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected record key=%0d tag=%0d last=%0d, nothing expected",
                         $time, k, t, mark);
                errors++;
                return;
            end
            want = due_q.pop_front();
            if (k !== want.key) begin
                $display("%0t: out_key mismatch, expected %0d, got %0d", $time, want.key, k);
                errors++;
            end
            if (t !== want.tag) begin
                $display("%0t: out_tag mismatch, expected %0d, got %0d", $time, want.tag, t);
                errors++;
            end
            if (mark !== want.last) begin
                $display("%0t: out_last mismatch, expected %0d, got %0d",
                         $time, want.last, mark);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tlast;

    sorted_record_board board;
    int                 burst_left = 0;
    int                 items_sent = 0;
    int                 cycle_cnt  = 0;
    stall_mode_t        stall_mode = RDY_ALWAYS;
    int                 stall_span = 0;

    record_key_exchange_sorter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a period of 4 time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog. The slowest legal run (every set at full size, each sort
    // sweeping the whole memory and every result waiting out a long stall)
    // stays far below this count.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d records still expected",
                     $time, board.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Master-side back pressure. The receiver switches between a few stall
    // patterns at random intervals, so stalls land on every record of a set,
    // including the one carrying tlast, and there are stretches with none.
    always @(posedge clk)
    begin
        if (stall_span == 0) begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_span <= $urandom_range(20, 80);
        end
        else begin
            stall_span <= stall_span - 1;
        end
        case (stall_mode)
            RDY_ALWAYS: m_axis_tready <= 1'b1;
            RDY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RDY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:    m_axis_tready <= ~m_axis_tready;
        endcase
    end

    // Every master-side transaction is checked against the oldest expected
    // record. Values are sampled at the edge, before any update it causes.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_output(m_axis_tdata[KEY_W-1:0],
                               m_axis_tdata[KEY_W+TAG_W-1:KEY_W],
                               m_axis_tlast);
    end

    // Send one record on the slave side. The sender works in bursts; when a
    // burst runs out it drops tvalid for a random gap before the next one.
    // tvalid is only lowered when a real gap follows, so it never gets two
    // updates in the same time step.
    task automatic push_record(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                               input logic mark);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_axis_tdata  <= {{PAD_W{1'b0}}, t, k};
        s_axis_tlast  <= mark;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_record(k, t, mark);
        burst_left--;
        items_sent++;
    endtask

    // Stop sending and hold off until every expected record has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // One random set of n records. Sets shorter than the memory always end
    // with tlast; a full set ends with tlast or closes on its size alone.
    task automatic push_random_set(input int n, input key_mode_t km);
        logic [KEY_W-1:0] k;
        logic             mark;
        for (int i = 0; i < n; i++) begin
            case (km)
                KEYS_NARROW:  k = KEY_W'($urandom_range(0, 3));
                KEYS_EXTREME: k = ($urandom_range(0, 1) == 1) ? 7'd127 : 7'd0;
                KEYS_HIGH:    k = KEY_W'($urandom_range(120, 127));
                default:      k = KEY_W'($urandom_range(0, 127));
            endcase
            if (i < n - 1)
                mark = 1'b0;
            else if (n == MAX_ITEMS)
                mark = 1'($urandom_range(0, 1));
            else
                mark = 1'b1;
            push_record(k, TAG_W'($urandom_range(0, 255)), mark);
        end
    endtask

    initial
    begin
        int        set_len;
        int        pick;
        key_mode_t km;

        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A set of one record with the largest key and tag.
        push_record(7'd127, 8'd255, 1'b1);

        // Extremes and ties: two zero keys and two equal middle keys.
        push_record(7'd0,   8'h00, 1'b0);
        push_record(7'd127, 8'hFF, 1'b0);
        push_record(7'd64,  8'hA5, 1'b0);
        push_record(7'd64,  8'h5A, 1'b0);
        push_record(7'd0,   8'h01, 1'b1);
        wait_drained();

        // Sixteen records and no tlast: the full memory closes the set.
        // Keys fall with pairs of equal values; tags tell the records apart.
        for (int i = 0; i < MAX_ITEMS; i++)
            push_record(7'((MAX_ITEMS - 1 - i) / 2 * 17), 8'(i * 17), 1'b0);

        // The next record must start a fresh set.
        push_record(7'd1, 8'h80, 1'b0);
        push_record(7'd0, 8'h7F, 1'b1);
        wait_drained();

        // Random sets, mostly short, some at full size.
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                set_len = $urandom_range(1, 6);
            else if (pick < 8)
                set_len = $urandom_range(7, MAX_ITEMS - 1);
            else
                set_len = MAX_ITEMS;
            km = key_mode_t'($urandom_range(0, 3));
            push_random_set(set_len, km);
            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (board.pending() != 0) begin
            $display("%0t: %0d expected records never arrived", $time, board.pending());
            board.errors++;
        end
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
